FILE: rtl/core/pifmt_pkg.sv
// Shared types, codes and character constants for the integer field formatter.
// No dependencies; every other file in rtl/core but pifmt_checker.sv imports this package.
package pifmt_pkg;

  localparam int MAX_FIELD_DEF = 60;
  localparam int NDIG          = 22;   // octal digits of a 64-bit operand
  localparam int ND_W          = 5;
  localparam int LEN_W         = 6;
  localparam int QDEPTH        = 2;

  localparam logic [2:0] CONV_SDEC = 3'd0;
  localparam logic [2:0] CONV_UDEC = 3'd1;
  localparam logic [2:0] CONV_OCT  = 3'd2;
  localparam logic [2:0] CONV_HEXL = 3'd3;
  localparam logic [2:0] CONV_HEXU = 3'd4;

  localparam logic [1:0] SIZE_SHORT = 2'd0;
  localparam logic [1:0] SIZE_INT   = 2'd1;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_X_LOWER = 8'h78;
  localparam logic [7:0] CH_X_UPPER = 8'h58;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_MINUS   = 8'h2D;

  typedef logic [NDIG-1:0][3:0] digits_t;

  // One classified item, handed from the front end to the emitter
  typedef struct packed {
    digits_t          digits;
    logic [ND_W-1:0]  nd;
    logic [LEN_W-1:0] lz;
    logic [LEN_W-1:0] pad;
    logic [7:0]       sign_c;
    logic             has_sign;
    logic             prefix;
    logic             upper;
    logic             left;
    logic             zfill;
  } desc_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base_c;
    base_c = upper ? CH_UPPER_A : CH_LOWER_A;
    if (d < 4'd10) begin
      digit_char = CH_ZERO + {4'b0, d};
    end else begin
      digit_char = base_c + {4'b0, d} - 8'd10;
    end
  endfunction

endpackage

FILE: rtl/core/pifmt_front.sv
// Front end: takes an item, sizes and signs the operand, builds the digits
// (shift-and-add-3 for decimal) and classifies padding. Uses pifmt_pkg.
module pifmt_front
  import pifmt_pkg::*;
#(
  parameter int MAX_FIELD = MAX_FIELD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_value,
  input  logic [1:0]  in_operand_size,
  input  logic [2:0]  in_conversion,
  input  logic        in_force_plus,
  input  logic        in_space_sign,
  input  logic        in_left_justify,
  input  logic        in_zero_pad,
  input  logic        in_alt_form,
  input  logic [5:0]  in_field_width,
  input  logic [5:0]  in_min_digits,
  input  logic        in_precision_given,
  output logic        push,
  output desc_t       push_desc,
  input  logic        q_full
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_PACK = 2'd3;
  localparam logic [LEN_W-1:0] SAT = LEN_W'(MAX_FIELD);

  logic [1:0]       state_r, state_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic [63:0]      sr_r, sr_nxt;
  digits_t          dig_r, dig_nxt;
  logic [2:0]       conv_r;
  logic             neg_r, plus_r, space_r, left_r, zpad_r, alt_r, pg_r, zero_r;
  logic [LEN_W-1:0] width_r, prec_r;
  logic [ND_W-1:0]  nd_r;

  // accept-side classification
  logic        accept;
  logic [63:0] masked, negv, mag;
  logic        msb, neg;
  logic [2:0]  conv_eff;
  logic [65:0] oct_ext;
  logic [87:0] hex_ext;
  digits_t     dig_oct, dig_hex, adj;
  logic [151:0] dd_shift;
  logic [ND_W-1:0] hi;

  // pack-side arithmetic
  logic [LEN_W-1:0] lz_base, lz, pad;
  logic [6:0]       body;
  logic             is_oct, is_hex, prefix, has_sign, empty;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    case (in_operand_size)
      SIZE_SHORT: begin
        masked = {48'b0, in_value[15:0]};
        msb    = in_value[15];
      end
      SIZE_INT: begin
        masked = {32'b0, in_value[31:0]};
        msb    = in_value[31];
      end
      default: begin
        masked = in_value;
        msb    = in_value[63];
      end
    endcase
    conv_eff = (in_conversion > CONV_HEXU) ? CONV_UDEC : in_conversion;
    neg      = (conv_eff == CONV_SDEC) && msb;
    negv     = 64'd0 - masked;
    case (in_operand_size)
      SIZE_SHORT: negv = {48'b0, negv[15:0]};
      SIZE_INT:   negv = {32'b0, negv[31:0]};
      default:    negv = negv;
    endcase
    mag     = neg ? negv : masked;
    oct_ext = {2'b00, mag};
    hex_ext = {24'b0, mag};
    for (int i = 0; i < NDIG; i++) begin
      dig_oct[i] = {1'b0, oct_ext[3*i +: 3]};
      dig_hex[i] = hex_ext[4*i +: 4];
    end
  end

  // shift-and-add-3 step: one operand bit per cycle
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[i] = (dig_r[i] >= 4'd5) ? dig_r[i] + 4'd3 : dig_r[i];
    end
    dd_shift = {adj, sr_r} << 1;
  end

  always_comb begin
    hi = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (dig_r[i] != 4'd0) hi = ND_W'(i + 1);
    end
  end

  always_comb begin
    is_oct   = (conv_r == CONV_OCT);
    is_hex   = (conv_r == CONV_HEXL) || (conv_r == CONV_HEXU);
    lz_base  = (prec_r > LEN_W'(nd_r)) ? prec_r - LEN_W'(nd_r) : '0;
    lz       = (alt_r && is_oct && lz_base == '0 && (nd_r == '0 || !zero_r))
               ? LEN_W'(1) : lz_base;
    prefix   = alt_r && is_hex && !zero_r;
    has_sign = (conv_r == CONV_SDEC) && (neg_r || plus_r || space_r);
    body     = 7'(has_sign) + {5'b0, prefix, 1'b0} + 7'(lz) + 7'(nd_r);
    pad      = ({1'b0, width_r} > body) ? LEN_W'({1'b0, width_r} - body) : '0;
    empty    = (body == 7'd0) && (pad == '0);

    push_desc.digits   = dig_r;
    push_desc.nd       = nd_r;
    push_desc.lz       = lz;
    push_desc.pad      = pad;
    push_desc.sign_c   = neg_r ? CH_MINUS : (plus_r ? CH_PLUS : CH_SPACE);
    push_desc.has_sign = has_sign;
    push_desc.prefix   = prefix;
    push_desc.upper    = (conv_r == CONV_HEXU);
    push_desc.left     = left_r;
    push_desc.zfill    = !left_r && zpad_r && !pg_r;
  end

  assign push = (state_r == ST_PACK) && !q_full && !empty;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sr_nxt    = sr_r;
    dig_nxt   = dig_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (conv_eff)
            CONV_OCT: begin
              dig_nxt   = dig_oct;
              state_nxt = ST_SCAN;
            end
            CONV_HEXL, CONV_HEXU: begin
              dig_nxt   = dig_hex;
              state_nxt = ST_SCAN;
            end
            default: begin
              dig_nxt   = '0;
              state_nxt = ST_CONV;
              case (in_operand_size)
                SIZE_SHORT: begin
                  sr_nxt  = mag << 48;
                  cnt_nxt = 6'd15;
                end
                SIZE_INT: begin
                  sr_nxt  = mag << 32;
                  cnt_nxt = 6'd31;
                end
                default: begin
                  sr_nxt  = mag;
                  cnt_nxt = 6'd63;
                end
              endcase
            end
          endcase
        end
      end
      ST_CONV: begin
        dig_nxt = dd_shift[151:64];
        sr_nxt  = dd_shift[63:0];
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd0) state_nxt = ST_SCAN;
      end
      ST_SCAN: state_nxt = ST_PACK;
      default: begin
        if (!q_full || empty) state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    sr_r  <= sr_nxt;
    dig_r <= dig_nxt;
    if (accept) begin
      conv_r  <= conv_eff;
      neg_r   <= neg;
      plus_r  <= in_force_plus;
      space_r <= in_space_sign;
      left_r  <= in_left_justify;
      zpad_r  <= in_zero_pad;
      alt_r   <= in_alt_form;
      pg_r    <= in_precision_given;
      width_r <= (in_field_width > SAT) ? SAT : in_field_width;
      prec_r  <= !in_precision_given ? LEN_W'(1) :
                 ((in_min_digits > SAT) ? SAT : in_min_digits);
    end
    if (state_r == ST_SCAN) begin
      zero_r <= (hi == '0);
      if (hi == '0) begin
        nd_r <= (pg_r && prec_r == '0) ? ND_W'(0) : ND_W'(1);
      end else begin
        nd_r <= hi;
      end
    end
  end

endmodule

FILE: rtl/core/pifmt_queue.sv
// Short descriptor queue between front end and emitter.
// Uses desc_t and QDEPTH from pifmt_pkg.
module pifmt_queue
  import pifmt_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_desc,
  output logic  q_full,
  input  logic  pop,
  output desc_t pop_desc,
  output logic  q_empty
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  desc_t            entry_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign q_full   = (cnt_r == CNT_W'(QDEPTH));
  assign q_empty  = (cnt_r == '0);
  assign pop_desc = entry_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_desc;
  end

endmodule

FILE: rtl/core/pifmt_back.sv
// Emitter: walks one descriptor character by character into an output register.
// Uses desc_t and character constants from pifmt_pkg.
module pifmt_back
  import pifmt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  desc_t      pop_desc,
  input  logic       q_empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_last
);

  logic             busy_r;
  logic [LEN_W-1:0] idx_r, total_r, b0_r, b1_r, b2_r, b4_r, b5_r;
  digits_t          dig_r;
  logic [7:0]       sign_r;
  logic             upper_r;
  logic             out_valid_r, out_last_r;
  logic [7:0]       out_char_r;

  logic [6:0]       lead, b1, b2, b4, b5, total;
  logic [LEN_W-1:0] dpos;
  logic [7:0]       ch;
  logic             advance, is_last;

  assign pop     = !busy_r && !q_empty;
  assign advance = busy_r && (!out_valid_r || !out_stall);
  assign is_last = (idx_r == total_r - LEN_W'(1));

  // segment boundaries: lead spaces, sign, prefix, zeros, digits, trail spaces
  always_comb begin
    lead  = (!pop_desc.left && !pop_desc.zfill) ? 7'(pop_desc.pad) : 7'd0;
    b1    = lead + 7'(pop_desc.has_sign);
    b2    = b1 + {5'b0, pop_desc.prefix, 1'b0};
    b4    = b2 + (pop_desc.zfill ? 7'(pop_desc.pad) : 7'd0) + 7'(pop_desc.lz);
    b5    = b4 + 7'(pop_desc.nd);
    total = b5 + (pop_desc.left ? 7'(pop_desc.pad) : 7'd0);
  end

  always_comb begin
    dpos = b5_r - LEN_W'(1) - idx_r;
    if (idx_r < b0_r) begin
      ch = CH_SPACE;
    end else if (idx_r < b1_r) begin
      ch = sign_r;
    end else if (idx_r < b2_r) begin
      ch = (idx_r == b1_r) ? CH_ZERO : (upper_r ? CH_X_UPPER : CH_X_LOWER);
    end else if (idx_r < b4_r) begin
      ch = CH_ZERO;
    end else if (idx_r < b5_r) begin
      ch = digit_char(dig_r[dpos[ND_W-1:0]], upper_r);
    end else begin
      ch = CH_SPACE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        busy_r <= 1'b1;
      end else if (advance && is_last) begin
        busy_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      idx_r   <= '0;
      b0_r    <= LEN_W'(lead);
      b1_r    <= LEN_W'(b1);
      b2_r    <= LEN_W'(b2);
      b4_r    <= LEN_W'(b4);
      b5_r    <= LEN_W'(b5);
      total_r <= LEN_W'(total);
      dig_r   <= pop_desc.digits;
      sign_r  <= pop_desc.sign_c;
      upper_r <= pop_desc.upper;
    end else if (advance) begin
      idx_r <= idx_r + LEN_W'(1);
    end
    if (advance) begin
      out_char_r <= ch;
      out_last_r <= is_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

endmodule

FILE: rtl/core/printf_integer_field_formatter_core.sv
// Top level of the integer field formatter: front end, descriptor queue, emitter.
// Depends on pifmt_pkg, pifmt_front, pifmt_queue and pifmt_back.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   value, size, conversion, flags, width, precision
//   out_     output     out_valid/out_stall out_char, out_last
//
// Front end: takes an item, then runs shift-and-add-3 over the 16, 32 or 64 operand bits
// for decimal (by operand size) or skips it for octal/hex, then classifies in SCAN and PACK.
// Emitter: loads a descriptor, then one character per cycle while out_stall allows, up to 62.
// Reset is synchronous and clears control state only; there is no clearing pass.
// Either side may stall freely; the two-entry queue decouples the halves.
module printf_integer_field_formatter_core
  import pifmt_pkg::*;
#(
  parameter int MAX_FIELD = MAX_FIELD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_value,
  input  logic [1:0]  in_operand_size,
  input  logic [2:0]  in_conversion,
  input  logic        in_force_plus,
  input  logic        in_space_sign,
  input  logic        in_left_justify,
  input  logic        in_zero_pad,
  input  logic        in_alt_form,
  input  logic [5:0]  in_field_width,
  input  logic [5:0]  in_min_digits,
  input  logic        in_precision_given,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        out_last
);

  logic  push, pop, q_full, q_empty;
  desc_t push_desc, pop_desc;

  pifmt_front #(
    .MAX_FIELD(MAX_FIELD)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_value           (in_value),
    .in_operand_size    (in_operand_size),
    .in_conversion      (in_conversion),
    .in_force_plus      (in_force_plus),
    .in_space_sign      (in_space_sign),
    .in_left_justify    (in_left_justify),
    .in_zero_pad        (in_zero_pad),
    .in_alt_form        (in_alt_form),
    .in_field_width     (in_field_width),
    .in_min_digits      (in_min_digits),
    .in_precision_given (in_precision_given),
    .push               (push),
    .push_desc          (push_desc),
    .q_full             (q_full)
  );

  pifmt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .q_full    (q_full),
    .pop       (pop),
    .pop_desc  (pop_desc),
    .q_empty   (q_empty)
  );

  pifmt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_desc  (pop_desc),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .out_last  (out_last)
  );

endmodule

FILE: rtl/core/pifmt_checker.sv
// Port-level checks for the integer field formatter, bound to the top level.
// Depends only on the top level's ports.
module pifmt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_char,
  input logic        out_last
);

  // a stalled character holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(out_last))
    else $error("stalled output changed");

  // the front end is busy in the cycle after each transfer
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on consecutive cycles");

  // stall only ever rises because an item was taken
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid && !in_stall))
    else $error("input stall rose without a transfer");

  // inside a field the characters come back to back
  a_field_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid)
    else $error("gap inside a field");

endmodule

bind printf_integer_field_formatter_core pifmt_checker u_pifmt_checker (.*);
